// ----- rtl/core/mshs_pkg.sv -----
// mshs_pkg: shared constants for the multiply-shift hash set
// field widths, op and status codes, register indexes, default geometry
// no dependencies
package mshs_pkg;

	// default table geometry
	localparam int BUCKET_BITS_DEF = 8;
	localparam int WAYS_DEF        = 4;

	// fixed field widths of the ports
	localparam int OP_W     = 2;
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int BUCKET_W = 8;
	localparam int WAY_W    = 2;
	localparam int COUNT_W  = 11;
	localparam int MULT_W   = 32;
	localparam int OFFSET_W = 24;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 1;

	// operation codes (the unused code behaves as a lookup)
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MULT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'd1;

endpackage

// ----- rtl/core/multiply_shift_hash_set.sv -----
// multiply_shift_hash_set: set of 32-bit keys with lookup, insert and delete
// hashed buckets with bounded ways, rows held in two synchronous memories
// depends on mshs_pkg
//
// Usage
//  - input channel (in_valid/in_ready, op, key): one operation per transfer
//  - output channel (out_valid/out_ready, status, bucket_index, way_index,
//    element_count, load_high): exactly one result per operation, in order
//  - config port: cfg_wr_en writes cfg_data into register cfg_index
//    (0 hash multiplier, 1 hash offset); write only while the block is idle
//  - an operation runs in order: accept and multiply, hash and row read,
//    compare and write back; the next operation is taken in the cycle after
//    write back, so a new operation is not taken before the last is written back
//  - this follows from the single row read-modify-write per operation on
//    the key and valid memories
//  - result: out_valid rises when write back loads the output register, after
//    the stage 1 registers and the stage 2 row read registers
//  - the result sits in an output register; a new operation may be accepted
//    while it waits, and write back of that next one waits until the output
//    register is free, so a stalled receiver holds the block after one op
//  - after reset the valid memory is cleared one bucket row per cycle,
//    all 2^BUCKET_BITS rows (256 by default), with in_ready low; config writes
//    are taken during that time
module multiply_shift_hash_set #(
	parameter int BUCKET_BITS = mshs_pkg::BUCKET_BITS_DEF,
	parameter int WAYS        = mshs_pkg::WAYS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [mshs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mshs_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [mshs_pkg::OP_W-1:0]             op,
	input  logic signed [mshs_pkg::KEY_W-1:0]     key,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mshs_pkg::STATUS_W-1:0]         status,
	output logic [mshs_pkg::BUCKET_W-1:0]         bucket_index,
	output logic [mshs_pkg::WAY_W-1:0]            way_index,
	output logic [mshs_pkg::COUNT_W-1:0]          element_count,
	output logic                                  load_high
);

	localparam int KEY_W       = mshs_pkg::KEY_W;
	localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
	localparam int NUM_SLOTS   = NUM_BUCKETS * WAYS;
	localparam int WAY_IW      = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
	localparam int ROW_W       = WAYS * KEY_W;
	localparam logic [CNT_W-1:0] LOAD_TH = CNT_W'(3 * (NUM_BUCKETS / 4));

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_UPDATE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [mshs_pkg::MULT_W-1:0]   mult_q;
	logic [mshs_pkg::OFFSET_W-1:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q   <= mshs_pkg::MULT_W'(1);
			offset_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mshs_pkg::REG_MULT:   mult_q   <= cfg_data[mshs_pkg::MULT_W-1:0];
				mshs_pkg::REG_OFFSET: offset_q <= cfg_data[mshs_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: operation and low half of the product
	logic [mshs_pkg::OP_W-1:0] op_s1;
	logic [KEY_W-1:0]          key_s1;
	logic [KEY_W-1:0]          prod_s1;
	logic                      in_xfer;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= op;
			key_s1  <= $unsigned(key);
			prod_s1 <= KEY_W'(mult_q * $unsigned(key));
		end
	end

	// stage 2: bucket select and row read
	logic [KEY_W-1:0]       hash_sum;
	logic [BUCKET_BITS-1:0] bucket_hash;
	logic [BUCKET_BITS-1:0] bucket_s2;
	logic                   rd_en;

	assign hash_sum    = prod_s1 + KEY_W'(offset_q);
	assign bucket_hash = hash_sum[KEY_W-1 -: BUCKET_BITS];
	assign rd_en       = (state_q == ST_HASH);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			bucket_s2 <= bucket_hash;
		end
	end

	// memories, one row per bucket
	logic [ROW_W-1:0]       key_mem [NUM_BUCKETS];
	logic [WAYS-1:0]        vld_mem [NUM_BUCKETS];
	logic [ROW_W-1:0]       key_row_s2;
	logic [WAYS-1:0]        vld_row_s2;
	logic [ROW_W-1:0]       key_row_new;
	logic [WAYS-1:0]        vld_row_new;
	logic                   key_we;
	logic                   vld_we;
	logic [BUCKET_BITS-1:0] vld_addr;
	logic [WAYS-1:0]        vld_wdata;
	logic [BUCKET_BITS-1:0] clr_q;
	logic                   clearing;

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[bucket_s2] <= key_row_new;
		end
		if (rd_en) begin
			key_row_s2 <= key_mem[bucket_hash];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_we) begin
			vld_mem[vld_addr] <= vld_wdata;
		end
		if (rd_en) begin
			vld_row_s2 <= vld_mem[bucket_hash];
		end
	end

	// way search: first matching valid way, first free way
	logic              hit;
	logic              has_free;
	logic [WAY_IW-1:0] hit_way;
	logic [WAY_IW-1:0] free_way;

	always_comb begin
		hit      = 1'b0;
		has_free = 1'b0;
		hit_way  = '0;
		free_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (vld_row_s2[w]) begin
				if (!hit && key_row_s2[w*KEY_W +: KEY_W] == key_s1) begin
					hit     = 1'b1;
					hit_way = WAY_IW'(w);
				end
			end else if (!has_free) begin
				has_free = 1'b1;
				free_way = WAY_IW'(w);
			end
		end
	end

	// decision and write back
	logic                          commit;
	logic                          ins_ok;
	logic                          del_ok;
	logic [mshs_pkg::STATUS_W-1:0] status_d;
	logic [WAY_IW-1:0]             way_d;
	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              cnt_d;

	assign commit = (state_q == ST_UPDATE) && (!out_valid || out_ready);

	always_comb begin
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		status_d = mshs_pkg::ST_ABSENT;
		way_d    = '0;
		priority if (op_s1 == mshs_pkg::OP_INSERT) begin
			if (hit) begin
				status_d = mshs_pkg::ST_PRESENT;
				way_d    = hit_way;
			end else if (!has_free) begin
				status_d = mshs_pkg::ST_FULL;
			end else begin
				ins_ok   = 1'b1;
				status_d = mshs_pkg::ST_OK;
				way_d    = free_way;
			end
		end else if (op_s1 == mshs_pkg::OP_DELETE) begin
			if (hit) begin
				del_ok   = 1'b1;
				status_d = mshs_pkg::ST_OK;
				way_d    = hit_way;
			end
		end else begin
			if (hit) begin
				status_d = mshs_pkg::ST_OK;
				way_d    = hit_way;
			end
		end
	end

	always_comb begin
		key_row_new = key_row_s2;
		key_row_new[free_way*KEY_W +: KEY_W] = key_s1;
		vld_row_new = vld_row_s2;
		if (ins_ok) begin
			vld_row_new[free_way] = 1'b1;
		end
		if (del_ok) begin
			vld_row_new[hit_way] = 1'b0;
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (ins_ok) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (del_ok) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	assign clearing  = (state_q == ST_CLEAR);
	assign key_we    = commit && ins_ok;
	assign vld_we    = clearing || (commit && (ins_ok || del_ok));
	assign vld_addr  = clearing ? clr_q : bucket_s2;
	assign vld_wdata = clearing ? '0 : vld_row_new;

	// result fields widened, then cut to port width
	logic [mshs_pkg::BUCKET_W+BUCKET_BITS-1:0] bucket_ext;
	logic [mshs_pkg::WAY_W+WAY_IW-1:0]         way_ext;
	logic [mshs_pkg::COUNT_W+CNT_W-1:0]        cnt_ext;

	assign bucket_ext = {{mshs_pkg::BUCKET_W{1'b0}}, bucket_s2};
	assign way_ext    = {{mshs_pkg::WAY_W{1'b0}}, way_d};
	assign cnt_ext    = {{mshs_pkg::COUNT_W{1'b0}}, cnt_d};

	// control and output register
	logic                          out_valid_q;
	logic [mshs_pkg::STATUS_W-1:0] status_q;
	logic [mshs_pkg::BUCKET_W-1:0] bucket_q;
	logic [mshs_pkg::WAY_W-1:0]    way_q;
	logic [mshs_pkg::COUNT_W-1:0]  count_q;
	logic                          load_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= '0;
			bucket_q    <= '0;
			way_q       <= '0;
			count_q     <= '0;
			load_q      <= 1'b0;
		end else begin
			// a result moved out with no new one behind it
			if (out_valid_q && out_ready && !commit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + BUCKET_BITS'(1);
					if (clr_q == {BUCKET_BITS{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					// hold until the output register can take the result
					if (commit) begin
						state_q     <= ST_IDLE;
						cnt_q       <= cnt_d;
						out_valid_q <= 1'b1;
						status_q    <= status_d;
						bucket_q    <= bucket_ext[mshs_pkg::BUCKET_W-1:0];
						way_q       <= way_ext[mshs_pkg::WAY_W-1:0];
						count_q     <= cnt_ext[mshs_pkg::COUNT_W-1:0];
						load_q      <= (cnt_d >= LOAD_TH);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign bucket_index  = bucket_q;
	assign way_index     = way_q;
	assign element_count = count_q;
	assign load_high     = load_q;

endmodule
